@@ design/met_pkg.sv @@
// Package for the Mandelbrot escape-time unit: widths, codes, shared types.
// No dependencies.
`default_nettype none
package met_pkg;
    localparam int FRAC_BITS_DEF  = 59;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CW  = 62;
    localparam int ZW  = 64;
    localparam int PW  = 128;
    localparam int THW = 63;

    localparam logic [1:0] REASON_ESCAPED = 2'd0;
    localparam logic [1:0] REASON_LIMIT   = 2'd1;
    localparam logic [1:0] REASON_CYCLE   = 2'd2;

    localparam logic [1:0] REG_MAX_ITER = 2'd0;
    localparam logic [1:0] REG_PERIOD   = 2'd1;
    localparam logic [1:0] REG_THRESH   = 2'd2;

    typedef struct packed {
        logic start;
        logic busy;
    } t_mul_ctl;
endpackage
`default_nettype wire

@@ design/met_serial_mul.sv @@
// Bit-serial unsigned 64x64 multiplier: one multiplier bit per cycle.
// Depends on met_pkg.
`default_nettype none
module met_serial_mul (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [met_pkg::ZW-1:0]  i_a,
    input  wire logic [met_pkg::ZW-1:0]  i_b,
    output logic                         o_done,
    output logic [met_pkg::PW-1:0]       o_p
);
    logic [met_pkg::ZW-1:0] r_a, r_b;
    logic [met_pkg::PW-1:0] r_p;
    logic [6:0] r_cnt;
    logic       r_busy;
    logic [met_pkg::ZW:0] n_sum;

    // shift-add: high half accumulates, product shifts right one bit a cycle
    assign n_sum = {1'b0, r_p[met_pkg::PW-1:met_pkg::ZW]}
                 + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_p    <= '0;
            end else if (r_busy) begin
                r_p   <= {n_sum, r_p[met_pkg::ZW-1:1]};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

@@ design/mandelbrot_escape_time_unit.sv @@
// Top level of the Mandelbrot escape-time unit: sequencer, registers, handshakes.
// Depends on met_pkg and met_serial_mul.
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata {c_imag, c_real}
//  m_axis    out  m_axis_tvalid/tready      tdata {end_reason, iteration_count}
//  cfg       in   i_cfg_valid/o_cfg_ready   index, data
// One point at a time. Each iteration is a test state and two rounds of the paired
// bit-serial multipliers (zr*zi, then zr^2 and zi^2).
// Cycle detection adds a distance round and a check state to each iteration.
// Reset restores register defaults.
// While a result waits in the output register tready stays low.
`default_nettype none
module mandelbrot_escape_time_unit #(
    parameter int FRAC_BITS  = met_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = met_pkg::COUNT_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // [61:0] c_real, [123:62] c_imag
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [15:0] iteration_count, [17:16] end_reason
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    localparam int ZW = met_pkg::ZW;
    localparam int PW = met_pkg::PW;
    localparam int FOURPOS = 2 * FRAC_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_TEST, S_MUL1, S_MUL2, S_DIST, S_CHECK, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_max, r_period;
    logic [62:0] r_thr;
    logic [ZW-1:0] r_cr, r_ci, r_zr, r_zi, r_rr, r_ri;
    logic [PW-1:0] r_sqr, r_sqi;
    logic          r_pneg;
    logic [COUNT_BITS-1:0] r_n, r_lim;
    logic [15:0] r_pc;
    logic [15:0] r_cnt_out;
    logic [1:0]  r_reason;
    logic        r_dist_ok;
    logic        r_kick;

    logic          m_start;
    logic [ZW-1:0] m0_a, m0_b, m1_a, m1_b;
    logic          m0_done, m1_done;
    logic [PW-1:0] m0_p, m1_p;

    met_serial_mul u_mul0 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start),
        .i_a(m0_a), .i_b(m0_b), .o_done(m0_done), .o_p(m0_p));
    met_serial_mul u_mul1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start),
        .i_a(m1_a), .i_b(m1_b), .o_done(m1_done), .o_p(m1_p));

    function automatic logic [ZW-1:0] magn(input logic [ZW-1:0] x);
        return x[ZW-1] ? (~x + ZW'(1)) : x;
    endfunction

    function automatic logic [ZW-1:0] absdiff(input logic [ZW-1:0] a, input logic [ZW-1:0] b);
        return ($signed(a) >= $signed(b)) ? a - b : b - a;
    endfunction

    logic [ZW-1:0] dr, di, n_zi, n_zr;
    logic [PW-1:0] prod_s, diff, mag_sum, four;
    logic [COUNT_BITS:0] cmax;
    logic [16:0] max_ext;

    assign four    = PW'(1) << FOURPOS;
    assign mag_sum = r_sqr + r_sqi;
    assign dr      = absdiff(r_zr, r_rr);
    assign di      = absdiff(r_zi, r_ri);
    // signed zr*zi straight from the multiplier as its round ends
    assign prod_s  = r_pneg ? (~m0_p + PW'(1)) : m0_p;
    assign diff    = r_sqr - r_sqi;
    assign n_zi    = ZW'(prod_s >> (FRAC_BITS - 1)) + r_ci;
    assign n_zr    = ZW'(diff >> FRAC_BITS) + r_cr;
    assign cmax    = {1'b0, {COUNT_BITS{1'b1}}};
    assign max_ext = {1'b0, r_max};

    always_comb begin
        m_start = r_kick;
        m0_a = magn(r_zr); m0_b = magn(r_zi);
        m1_a = '0;         m1_b = '0;
        unique case (r_state)
            S_MUL2: begin m0_a = magn(r_zr); m0_b = magn(r_zr);
                          m1_a = magn(r_zi); m1_b = magn(r_zi); end
            S_DIST: begin m0_a = dr; m0_b = dr; m1_a = di; m1_b = di; end
            default: ;
        endcase
        if ((r_state == S_TEST) && (mag_sum <= four) && (r_n < r_lim))
            m_start = 1'b1;
    end

    logic [63:0] s1, s2;
    assign s1 = m0_p[63:0];
    assign s2 = m1_p[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max <= 16'd256; r_period <= 16'd0;
            r_thr <= 63'd3323069989462290;
            m_axis_tvalid <= 1'b0;
            r_kick <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    met_pkg::REG_MAX_ITER: r_max    <= i_cfg_data[15:0];
                    met_pkg::REG_PERIOD:   r_period <= i_cfg_data[15:0];
                    met_pkg::REG_THRESH:   r_thr    <= i_cfg_data[62:0];
                    default: ;
                endcase
            end
            // start pulse for the squares round and the distance round
            r_kick <= ((r_state == S_MUL1) && m0_done)
                   || ((r_state == S_MUL2) && m0_done && (r_period != 16'd0));
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_cr <= ZW'($signed(s_axis_tdata[61:0]));
                    r_ci <= ZW'($signed(s_axis_tdata[123:62]));
                    r_zr <= '0; r_zi <= '0; r_rr <= '0; r_ri <= '0;
                    r_sqr <= '0; r_sqi <= '0; r_n <= '0; r_pc <= '0;
                    r_lim <= (max_ext < 17'(cmax)) ? COUNT_BITS'(r_max)
                                                   : {COUNT_BITS{1'b1}};
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (mag_sum > four) begin
                        r_reason <= met_pkg::REASON_ESCAPED;
                        r_cnt_out <= 16'(r_n); r_state <= S_OUT;
                    end else if (r_n >= r_lim) begin
                        r_reason <= met_pkg::REASON_LIMIT;
                        r_cnt_out <= 16'(r_n); r_state <= S_OUT;
                    end else begin
                        r_pneg <= r_zr[ZW-1] ^ r_zi[ZW-1];
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: if (m0_done) begin
                    r_zr <= n_zr; r_zi <= n_zi;
                    r_n <= r_n + COUNT_BITS'(1);
                    r_pc <= (r_pc + 16'd1 == r_period) ? 16'd0 : r_pc + 16'd1;
                    r_state <= S_MUL2;
                end
                S_MUL2: if (m0_done && m1_done) begin
                    r_sqr <= m0_p; r_sqi <= m1_p;
                    r_state <= (r_period != 16'd0) ? S_DIST : S_TEST;
                end
                S_DIST: begin
                    r_dist_ok <= (dr[63:32] == '0) && (di[63:32] == '0);
                    if (m0_done && m1_done) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_dist_ok && (s1 < {1'b0, r_thr})
                        && (s2 < ({1'b0, r_thr} - s1))) begin
                        r_reason <= met_pkg::REASON_CYCLE;
                        r_cnt_out <= 16'(r_lim); r_state <= S_OUT;
                    end else begin
                        if (r_pc == 16'd0) begin r_rr <= r_zr; r_ri <= r_zi; end
                        r_state <= S_TEST;
                    end
                end
                S_OUT: if (!m_axis_tvalid) begin
                    m_axis_tvalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {6'd0, r_reason, r_cnt_out};
endmodule
`default_nettype wire
